FILE: sv/svm_pkg.sv
package svm_pkg;

    // Instruction codes carried in the func field.
    localparam logic [3:0] OP_CONST    = 4'd0;
    localparam logic [3:0] OP_ADD      = 4'd1;
    localparam logic [3:0] OP_SUB      = 4'd2;
    localparam logic [3:0] OP_PRINT    = 4'd3;
    localparam logic [3:0] OP_CMP      = 4'd4;
    localparam logic [3:0] OP_JUMP     = 4'd5;
    localparam logic [3:0] OP_JUMPEQ   = 4'd6;
    localparam logic [3:0] OP_DUP      = 4'd7;
    localparam logic [3:0] OP_GLOAD    = 4'd8;
    localparam logic [3:0] OP_GSTORE   = 4'd9;
    localparam logic [3:0] OP_LOAD     = 4'd10;
    localparam logic [3:0] OP_STORE    = 4'd11;
    localparam logic [3:0] OP_CALL     = 4'd12;
    localparam logic [3:0] OP_RET      = 4'd13;
    // Codes with no instruction behind them; they always fault.
    localparam logic [3:0] OP_UNUSED14 = 4'd14;
    localparam logic [3:0] OP_UNUSED15 = 4'd15;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] immediate;
        logic [15:0]        fallthrough_address;
    } instr_t;

    typedef struct packed {
        logic [15:0]        next_address;
        logic               print_valid;
        logic signed [31:0] print_value;
        logic               fault;
    } result_t;

endpackage

FILE: sv/svm_stream_if.sv
interface svm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/stack_vm_execute_unit.sv
// An accepted instruction is registered and then executed; its result is written to the
// output register when it commits (later while the previous result is still unclaimed).
// A new instruction is taken only once the previous one is through, reading the stack on
// accept and writing it on execute; a call adds a state: its two stack writes share a port.
// Reset: the stack is empty, the frame base and equal flag are zero, all globals read
// as zero; the stack memory contents are not cleared.
module stack_vm_execute_unit #(
    parameter int STACK_DEPTH     = 256,
    parameter int GLOBAL_DEPTH    = 256,
    parameter int LOCAL_SLOTS     = 10,
    parameter int CODE_ADDR_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    svm_stream_if.sink   instr,
    svm_stream_if.source result
);

    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = SW + 1;          // entry count, 0..STACK_DEPTH
    localparam int XW = CW + 8;          // count plus a call frame
    localparam int GW = (GLOBAL_DEPTH > 1) ? $clog2(GLOBAL_DEPTH) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_CALL2 = 2'd2;

    // Architectural state kept in registers.
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] fb_reg, fb_next;
    logic          flag_reg, flag_next;
    logic [SW-1:0] saved_fb_reg;

    // The instruction being executed.
    svm_pkg::instr_t op_reg;

    // Operand stack and global store. Both are read in the accept cycle (the stack at two
    // addresses) and written in the execute cycle; a call writes the stack again after that.
    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] glob_mem  [GLOBAL_DEPTH];
    logic [GLOBAL_DEPTH-1:0] gvalid_reg;

    logic [31:0] rd_a_reg, rd_b_reg, g_rd_reg;
    logic        g_vld_reg;

    logic          accept;
    logic [SW-1:0] rd_a_addr, rd_b_addr;

    // Result register: it parts the execute logic from the consumer.
    logic              out_valid_reg;
    svm_pkg::result_t  out_reg;
    logic              out_free;

    assign instr.ready  = (state_reg == S_IDLE);
    assign accept       = instr.valid && instr.ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;
    assign out_free     = !out_valid_reg || result.ready;

    function automatic logic code_ok(logic [31:0] v);
        return !v[31] && ((v >> CODE_ADDR_WIDTH) == 32'd0);
    endfunction

    // Read addresses are formed from the incoming transaction and the current
    // pointers; the pointers cannot change before this instruction executes.
    always_comb
    begin
        rd_a_addr = SW'(cnt_reg - CW'(1));
        rd_b_addr = SW'(cnt_reg - CW'(2));
        case (instr.data.func)
            svm_pkg::OP_RET:
            begin
                rd_a_addr = fb_reg;
                rd_b_addr = fb_reg - SW'(1);
            end
            svm_pkg::OP_LOAD:
            begin
                rd_b_addr = fb_reg + SW'(instr.data.immediate);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= instr.data;
            rd_a_reg  <= stack_mem[rd_a_addr];
            rd_b_reg  <= stack_mem[rd_b_addr];
            g_rd_reg  <= glob_mem[GW'(instr.data.immediate)];
            g_vld_reg <= gvalid_reg[GW'(instr.data.immediate)];
        end
    end

    // Execute: checks, arithmetic and the next pointer values.
    logic               has1, has2, full, g_ok, fidx_ok, call_over;
    logic signed [33:0] fidx;
    logic [XW-1:0]      call_top;
    logic               fault;
    logic [15:0]        next_addr;
    logic               pvalid;
    logic [31:0]        pval;
    logic               wr_en;
    logic [SW-1:0]      wr_addr;
    logic [31:0]        wr_data;
    logic               gwr_en;
    logic               commit;
    logic [31:0]        gload_val;

    assign commit    = (state_reg == S_EXEC) && out_free;
    assign has1      = (cnt_reg != '0);
    assign has2      = (cnt_reg >= CW'(2));
    assign full      = (cnt_reg >= CW'(STACK_DEPTH));
    assign g_ok      = !op_reg.immediate[31] && (op_reg.immediate < 32'(GLOBAL_DEPTH));
    assign fidx      = 34'($signed({1'b0, fb_reg})) + 34'(op_reg.immediate);
    assign fidx_ok   = !fidx[33] && (fidx[32:0] < 33'(STACK_DEPTH));
    assign call_top  = XW'(cnt_reg) + XW'(LOCAL_SLOTS + 1);
    assign call_over = (call_top >= XW'(STACK_DEPTH));
    assign gload_val = g_vld_reg ? g_rd_reg : 32'd0;

    always_comb
    begin
        fault     = 1'b0;
        next_addr = op_reg.fallthrough_address;
        pvalid    = 1'b0;
        pval      = 32'd0;
        cnt_next  = cnt_reg;
        fb_next   = fb_reg;
        flag_next = flag_reg;
        wr_en     = 1'b0;
        wr_addr   = SW'(cnt_reg);
        wr_data   = op_reg.immediate;
        gwr_en    = 1'b0;
        case (op_reg.func)
            svm_pkg::OP_CONST:
            begin
                fault    = full;
                wr_en    = 1'b1;
                cnt_next = cnt_reg + CW'(1);
            end
            svm_pkg::OP_ADD, svm_pkg::OP_SUB:
            begin
                fault    = !has2;
                wr_en    = 1'b1;
                wr_addr  = SW'(cnt_reg - CW'(2));
                wr_data  = (op_reg.func == svm_pkg::OP_ADD) ? rd_a_reg + rd_b_reg
                                                             : rd_b_reg - rd_a_reg;
                cnt_next = cnt_reg - CW'(1);
            end
            svm_pkg::OP_PRINT:
            begin
                fault    = !has1;
                pvalid   = 1'b1;
                pval     = rd_a_reg;
                cnt_next = cnt_reg - CW'(1);
            end
            svm_pkg::OP_CMP:
            begin
                fault     = !has2;
                flag_next = (rd_a_reg == rd_b_reg);
                cnt_next  = cnt_reg - CW'(2);
            end
            svm_pkg::OP_JUMP, svm_pkg::OP_JUMPEQ:
            begin
                cnt_next = cnt_reg - CW'(1);
                if (!has1)
                begin
                    fault = 1'b1;
                end
                else if (op_reg.func == svm_pkg::OP_JUMP || flag_reg)
                begin
                    fault     = !code_ok(rd_a_reg);
                    next_addr = rd_a_reg[15:0];
                end
            end
            svm_pkg::OP_DUP:
            begin
                fault    = !has1 || full;
                wr_en    = 1'b1;
                wr_data  = rd_a_reg;
                cnt_next = cnt_reg + CW'(1);
            end
            svm_pkg::OP_GLOAD:
            begin
                fault    = !g_ok || full;
                wr_en    = 1'b1;
                wr_data  = gload_val;
                cnt_next = cnt_reg + CW'(1);
            end
            svm_pkg::OP_GSTORE:
            begin
                fault    = !g_ok || !has1;
                gwr_en   = 1'b1;
                cnt_next = cnt_reg - CW'(1);
            end
            svm_pkg::OP_LOAD:
            begin
                fault    = !fidx_ok || full;
                wr_en    = 1'b1;
                wr_data  = rd_b_reg;
                cnt_next = cnt_reg + CW'(1);
            end
            svm_pkg::OP_STORE:
            begin
                fault    = !fidx_ok || !has1;
                wr_en    = 1'b1;
                wr_addr  = fidx[SW-1:0];
                wr_data  = rd_a_reg;
                cnt_next = cnt_reg - CW'(1);
            end
            svm_pkg::OP_CALL:
            begin
                // Return address goes here; the old frame base follows next cycle.
                fault     = !code_ok(op_reg.immediate) || call_over;
                wr_en     = 1'b1;
                wr_data   = {16'd0, op_reg.fallthrough_address};
                fb_next   = SW'(cnt_reg + CW'(1));
                cnt_next  = CW'(call_top + XW'(1));
                next_addr = op_reg.immediate[15:0];
            end
            svm_pkg::OP_RET:
            begin
                fault     = (fb_reg == '0) || rd_a_reg[31]
                            || (rd_a_reg >= 32'(STACK_DEPTH)) || !code_ok(rd_b_reg);
                cnt_next  = CW'(fb_reg) - CW'(1);
                fb_next   = SW'(rd_a_reg);
                next_addr = rd_b_reg[15:0];
            end
            default:
            begin
                fault = 1'b1;
            end
        endcase
        if (fault)
        begin
            next_addr = op_reg.fallthrough_address;
            pvalid    = 1'b0;
            pval      = 32'd0;
            cnt_next  = cnt_reg;
            fb_next   = fb_reg;
            flag_next = flag_reg;
            wr_en     = 1'b0;
            gwr_en    = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next = (op_reg.func == svm_pkg::OP_CALL && !fault) ? S_CALL2
                                                                             : S_IDLE;
                end
            end
            S_CALL2:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            fb_reg        <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            gvalid_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                cnt_reg       <= cnt_next;
                fb_reg        <= fb_next;
                flag_reg      <= flag_next;
                out_valid_reg <= 1'b1;
                if (gwr_en)
                begin
                    gvalid_reg[GW'(op_reg.immediate)] <= 1'b1;
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_reg.next_address <= next_addr;
            out_reg.print_valid  <= pvalid;
            out_reg.print_value  <= pval;
            out_reg.fault        <= fault;
            saved_fb_reg         <= fb_reg;
        end
    end

    // Single write port of the stack: the execute write, or the saved frame
    // base of a call in the cycle after.
    always_ff @(posedge clk)
    begin
        if (commit && wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        else if (state_reg == S_CALL2)
        begin
            stack_mem[fb_reg] <= {{(32 - SW){1'b0}}, saved_fb_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && gwr_en)
        begin
            glob_mem[GW'(op_reg.immediate)] <= rd_a_reg;
        end
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_EXEC)
        else $error("accepted instruction did not enter execute");

    a_call2_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CALL2 |-> $past(state_reg) == S_EXEC)
        else $error("second call write without a call");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_fb_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fb_reg) < 32'(STACK_DEPTH))
        else $error("frame base beyond depth");

endmodule
